// ----- rtl/core/pwm_angle_encoder_decoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// PWM angle decoder assertion macros
// Concurrent assertion wrappers on clock and reset; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PWM_ANGLE_ENCODER_DECODER_CORE_DEFINES_SVH
`define PWM_ANGLE_ENCODER_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PAED_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define PAED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PAED_ASSERT_NOW(label, ante, cons, msg)
`define PAED_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/pwm_aed_pkg.sv -----
// ----------------------------------------------------------------------------
// PWM angle decoder package
// Shared widths, constants, register indexes and inter-module types.
// ----------------------------------------------------------------------------
package pwm_aed_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned PULSE_W     = 16;
   localparam int unsigned ANGLE_W     = 16;
   localparam int unsigned THR_W       = 15;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   // 360 and 180 degrees in 1/128 degree units
   localparam logic [ANGLE_W-1:0] ANGLE_FULL = 16'd46080;
   localparam logic [ANGLE_W-1:0] ANGLE_HALF = 16'd23040;

   localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 16'd0;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 16'd4096;
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 15'd128;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PULSE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PULSE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam int unsigned RSP_PULSE_VALID_BIT = 0;
   localparam int unsigned RSP_UPDATED_BIT     = 1;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   typedef struct packed {
      logic               pulse_valid;
      logic [PULSE_W-1:0] width_us;
   } pwm_aed_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pwm_aed_queue_status_type;

endpackage

// ----- rtl/core/pwm_aed_front.sv -----
// ----------------------------------------------------------------------------
// PWM angle decoder front end
// Accepts pin edges, tracks the rising edge and classifies each falling edge.
// ----------------------------------------------------------------------------
module pwm_aed_front
   import pwm_aed_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_level,
   input  logic [TIME_W-1:0]        req_time_us,
   input  logic [PULSE_W-1:0]       min_pulse_us,
   input  logic [PULSE_W-1:0]       max_pulse_us,
   input  pwm_aed_queue_status_type queue_status,
   output logic                     push,
   output pwm_aed_item_type         push_item
);

   logic [TIME_W-1:0] rise_time_ff, rise_time_in;
   logic              rise_seen_ff, rise_seen_in;
   logic [TIME_W-1:0] width_full;
   logic              in_range;

   assign req_tready = !queue_status.full;
   assign push       = req_tvalid && req_tready;

   // wrapped difference handles timestamp roll-over
   assign width_full = req_time_us - rise_time_ff;
   assign in_range   = (width_full > TIME_W'(min_pulse_us)) &&
                       (width_full < TIME_W'(max_pulse_us));

   assign push_item.pulse_valid = !req_level && rise_seen_ff && in_range;
   assign push_item.width_us    = width_full[PULSE_W-1:0];

   assign rise_seen_in = (push && req_level) ? 1'b1 : rise_seen_ff;
   assign rise_time_in = (push && req_level) ? req_time_us : rise_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_seen_ff <= 1'b0;
      end else begin
         rise_seen_ff <= rise_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      rise_time_ff <= rise_time_in;
   end

endmodule

// ----- rtl/core/pwm_aed_fifo.sv -----
// ----------------------------------------------------------------------------
// PWM angle decoder queue
// Short first-in first-out buffer between front and back end.
// ----------------------------------------------------------------------------
module pwm_aed_fifo
   import pwm_aed_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pwm_aed_item_type         push_item,
   input  logic                     pop,
   output pwm_aed_item_type         head_item,
   output pwm_aed_queue_status_type status
);

   pwm_aed_item_type       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ----- rtl/core/pwm_aed_back.sv -----
// ----------------------------------------------------------------------------
// PWM angle decoder back end
// Scales width to angle, applies the circular threshold and drives results.
// ----------------------------------------------------------------------------
module pwm_aed_back
   import pwm_aed_pkg::*;
#(
   parameter int unsigned FULL_SCALE_US = 3933
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pwm_aed_item_type     head_item,
   input  logic                 head_valid,
   output logic                 pop,
   input  logic [THR_W-1:0]     angle_threshold,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser
);

   localparam logic [PULSE_W-1:0] FULL_SCALE = PULSE_W'(FULL_SCALE_US);
   // floor(2^32 / full scale); estimate is then exact or one low
   localparam longint unsigned RECIP_VAL = (64'd1 << 32) / FULL_SCALE_US;
   localparam int unsigned     RECIP_W   = $clog2(RECIP_VAL + 1);
   localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_VAL);
   localparam int unsigned     PROD_W    = 32 + RECIP_W;

   logic enable;

   // stage 1: width times full angle
   logic               s1_valid_ff;
   logic               s1_pv_ff, s1_sat_ff;
   logic [PULSE_W-1:0] s1_width_ff;
   logic [31:0]        s1_p_ff, s1_p_in;
   // stage 2: reciprocal multiply
   logic               s2_valid_ff;
   logic               s2_pv_ff, s2_sat_ff;
   logic [PULSE_W-1:0] s2_width_ff;
   logic [31:0]        s2_p_ff;
   logic [PROD_W-1:0]  s2_prod_in;
   logic [ANGLE_W-1:0] s2_q_ff;
   // stage 3: back-multiply the estimate
   logic               s3_valid_ff;
   logic               s3_pv_ff, s3_sat_ff;
   logic [PULSE_W-1:0] s3_width_ff;
   logic [31:0]        s3_p_ff;
   logic [ANGLE_W-1:0] s3_q_ff;
   logic [31:0]        s3_qd_ff, s3_qd_in;
   // stage 4: correct and saturate
   logic               s4_valid_ff;
   logic               s4_pv_ff;
   logic [PULSE_W-1:0] s4_width_ff;
   logic [ANGLE_W-1:0] s4_angle_ff, s4_angle_in;
   logic [31:0]        remainder;
   // result stage
   logic               rsp_valid_ff;
   logic [1:0]         rsp_flags_ff, rsp_flags_in;
   logic [ANGLE_W-1:0] held_angle_ff, held_angle_in;
   logic [PULSE_W-1:0] held_width_ff, held_width_in;
   logic [ANGLE_W-1:0] diff, circ_dist;
   logic               do_update;

   // whole pipe advances unless the result is stalled
   assign enable = !rsp_valid_ff || rsp_tready;
   assign pop    = enable && head_valid;

   assign s1_p_in    = 32'(head_item.width_us) * 32'(ANGLE_FULL);
   assign s2_prod_in = PROD_W'(s1_p_ff) * PROD_W'(RECIP);
   assign s3_qd_in   = 32'(s2_q_ff) * 32'(FULL_SCALE);
   assign remainder  = s3_p_ff - s3_qd_ff;

   always_comb begin
      if (s3_sat_ff) begin
         s4_angle_in = ANGLE_FULL;
      end else if (remainder >= 32'(FULL_SCALE)) begin
         s4_angle_in = s3_q_ff + 1'b1;
      end else begin
         s4_angle_in = s3_q_ff;
      end
   end

   // circular distance from the held angle
   assign diff = (s4_angle_ff >= held_angle_ff) ? s4_angle_ff - held_angle_ff
                                                : held_angle_ff - s4_angle_ff;
   assign circ_dist = (diff > ANGLE_HALF) ? ANGLE_FULL - diff : diff;
   assign do_update = s4_pv_ff && (circ_dist >= ANGLE_W'(angle_threshold));

   assign held_angle_in = do_update ? s4_angle_ff : held_angle_ff;
   assign held_width_in = do_update ? s4_width_ff : held_width_ff;

   always_comb begin
      rsp_flags_in                      = '0;
      rsp_flags_in[RSP_PULSE_VALID_BIT] = s4_pv_ff;
      rsp_flags_in[RSP_UPDATED_BIT]     = do_update;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         held_angle_ff <= '0;
         held_width_ff <= '0;
      end else if (enable) begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
         if (s4_valid_ff) begin
            held_angle_ff <= held_angle_in;
            held_width_ff <= held_width_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_pv_ff     <= head_item.pulse_valid;
         s1_sat_ff    <= (head_item.width_us >= FULL_SCALE);
         s1_width_ff  <= head_item.width_us;
         s1_p_ff      <= s1_p_in;

         s2_pv_ff     <= s1_pv_ff;
         s2_sat_ff    <= s1_sat_ff;
         s2_width_ff  <= s1_width_ff;
         s2_p_ff      <= s1_p_ff;
         s2_q_ff      <= s2_prod_in[32 +: ANGLE_W];

         s3_pv_ff     <= s2_pv_ff;
         s3_sat_ff    <= s2_sat_ff;
         s3_width_ff  <= s2_width_ff;
         s3_p_ff      <= s2_p_ff;
         s3_q_ff      <= s2_q_ff;
         s3_qd_ff     <= s3_qd_in;

         s4_pv_ff     <= s3_pv_ff;
         s4_width_ff  <= s3_width_ff;
         s4_angle_ff  <= s4_angle_in;

         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {held_width_ff, held_angle_ff};
   assign rsp_tuser  = rsp_flags_ff;

endmodule

// ----- rtl/core/pwm_angle_encoder_decoder_core.sv -----
// ----------------------------------------------------------------------------
// PWM angle decoder core
// Turns pin edges of a PWM absolute encoder into a latched angle and width.
// ----------------------------------------------------------------------------
// Feed one transfer per pin edge: tuser carries the level after the edge and
// tdata the free-running microsecond timestamp. Every edge returns exactly
// one result transfer, in order, carrying the held angle (1/128 degree,
// 46080 = 360 degrees) and its pulse width, plus flags for an accepted pulse
// and for a new latch. The block takes one edge per clock and delivers one
// result per clock when neither side stalls. An accepted edge passes through
// the queue, the four-stage constant-divide scaling pipe (width times 46080,
// reciprocal multiply, back-multiply, correction) and the result register.
// A four-entry queue between the edge classifier and the scaling pipe lets
// input keep flowing until it fills while the result side is held off.
// Write the limit and threshold registers only while no edge is in flight.
// ----------------------------------------------------------------------------
`include "pwm_angle_encoder_decoder_core_defines.svh"

module pwm_angle_encoder_decoder_core
   import pwm_aed_pkg::*;
#(
   parameter int unsigned FULL_SCALE_US = 3933
) (
   input  logic                   clock,
   input  logic                   reset,
   // edge input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TIME_W-1:0]      req_tdata,   // [31:0] time_us
   input  logic                   req_tuser,   // [0] level
   // result output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // [15:0] angle, [31:16] width_us
   output logic [1:0]             rsp_tuser,   // [0] pulse_valid, [1] updated
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [PULSE_W-1:0] min_pulse_ff, min_pulse_in;
   logic [PULSE_W-1:0] max_pulse_ff, max_pulse_in;
   logic [THR_W-1:0]   threshold_ff, threshold_in;
   logic               csr_write;

   pwm_aed_queue_status_type queue_status;
   pwm_aed_item_type         push_item;
   pwm_aed_item_type         head_item;
   logic                     push;
   logic                     pop;

   // Registers: always ready, a write to an unused index is dropped.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      min_pulse_in = min_pulse_ff;
      max_pulse_in = max_pulse_ff;
      threshold_in = threshold_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_PULSE: min_pulse_in = csr_data;
            CSR_MAX_PULSE: max_pulse_in = csr_data;
            CSR_THRESHOLD: threshold_in = csr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff <= MIN_PULSE_RESET;
         max_pulse_ff <= MAX_PULSE_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         min_pulse_ff <= min_pulse_in;
         max_pulse_ff <= max_pulse_in;
         threshold_ff <= threshold_in;
      end
   end

   // Front end: hold the rising-edge time, measure and range-check widths.
   pwm_aed_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_level    (req_tuser),
      .req_time_us  (req_tdata),
      .min_pulse_us (min_pulse_ff),
      .max_pulse_us (max_pulse_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_item    (push_item)
   );

   // Queue: decouple edge intake from the scaling pipe.
   pwm_aed_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   // Back end: scale to angle, apply threshold, latch and drive results.
   pwm_aed_back #(
      .FULL_SCALE_US (FULL_SCALE_US)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_item       (head_item),
      .head_valid      (!queue_status.empty),
      .pop             (pop),
      .angle_threshold (threshold_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser)
   );

   // An accepted edge is in the queue on the next cycle.
   `PAED_ASSERT_NEXT(a_push_fills_queue, req_tvalid && req_tready, !queue_status.empty, "accepted edge missing from queue")

   // A latch only follows an accepted pulse and stays within a full turn.
   `PAED_ASSERT_NOW(a_update_needs_pulse, rsp_tvalid && rsp_tuser[RSP_UPDATED_BIT], rsp_tuser[RSP_PULSE_VALID_BIT] && (rsp_tdata[15:0] <= ANGLE_FULL), "latch without valid pulse")

   // Without a latch the held angle carries over from the previous result.
   `PAED_ASSERT_NOW(a_angle_held, rsp_tvalid && !rsp_tuser[RSP_UPDATED_BIT] && $past(rsp_tvalid), rsp_tdata[15:0] == $past(rsp_tdata[15:0]), "held angle changed without latch")

endmodule
